// ===== hw/rtl/bqir_pkg.sv =====
// Shared types and constants for the bounded queue with indexed removal.
package bqir_pkg;

  localparam int TIME_W = 16;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_REM = 1'b1
  } opcode_t;

  typedef struct packed {
    logic    load;
    logic    append;
    logic    read_pos;
    logic    capture;
    logic    shift;
    logic    shrink;
    logic    set_status;
    status_t status_code;
  } cmd_t;

  typedef struct packed {
    logic is_rem;
    logic count_zero;
    logic enq_ok;
    logic pos_ok;
    logic more;
  } sts_t;

endpackage

// ===== hw/rtl/bqir_ctrl.sv =====
// Controller state machine that sequences enqueue and remove transactions.
module bqir_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output bqir_pkg::cmd_t cmd,
  input  bqir_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_MOVE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state == S_CHECK) || (state == S_READ) || (state == S_MOVE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = bqir_pkg::ST_OK;
    case (state)
      S_IDLE, S_DONE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (!sts.is_rem) begin
          cmd.set_status  = 1'b1;
          cmd.append      = sts.enq_ok;
          cmd.status_code = sts.enq_ok ? bqir_pkg::ST_OK : bqir_pkg::ST_FULL;
          state_next      = S_DONE;
        end else if (sts.count_zero) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = bqir_pkg::ST_EMPTY;
          state_next      = S_DONE;
        end else if (!sts.pos_ok) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = bqir_pkg::ST_RANGE;
          state_next      = S_DONE;
        end else begin
          cmd.read_pos = 1'b1;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_next  = S_MOVE;
      end
      S_MOVE: begin
        if (sts.more) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.shrink      = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = bqir_pkg::ST_OK;
          state_next      = S_DONE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state_next == S_DONE);
    end
  end

  a_start_checks: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_CHECK))
    else $error("accepted transaction did not enter check");

  a_move_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE && !sts.more) |=> done)
    else $error("finished compaction without result strobe");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_CHECK || $past(state) == S_MOVE))
    else $error("result strobe from unexpected state");

endmodule

// ===== hw/rtl/bqir_dpath.sv =====
// Datapath: entry memory, count, capacity register and result registers.
module bqir_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bqir_pkg::cmd_t                cmd,
  output bqir_pkg::sts_t                sts,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bqir_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          opcode,
  input  logic [bqir_pkg::TIME_W-1:0]   task_time,
  input  logic [bqir_pkg::POS_W-1:0]    position,
  output logic [bqir_pkg::TIME_W-1:0]   removed_time,
  output logic [bqir_pkg::STAT_W-1:0]   status,
  output logic [bqir_pkg::CNT_W-1:0]    occupancy,
  output logic                          is_empty,
  output logic                          is_full
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [8:0] DEPTH_V = 9'(QUEUE_DEPTH);

  logic [bqir_pkg::TIME_W-1:0] mem [QUEUE_DEPTH];
  logic [bqir_pkg::TIME_W-1:0] rd_data;
  logic [AW-1:0]               rd_addr;

  logic [bqir_pkg::CNT_W-1:0]  count;
  logic [bqir_pkg::CNT_W-1:0]  cap;
  logic [bqir_pkg::CNT_W-1:0]  idx;
  logic                        op;
  logic [bqir_pkg::TIME_W-1:0] value;
  logic [bqir_pkg::POS_W-1:0]  pos;

  logic [8:0] cap_w;
  logic [8:0] cap_eff;
  logic [8:0] count_w;

  assign cap_w   = {4'b0, cap};
  assign count_w = {4'b0, count};
  assign cap_eff = (cap == '0) ? 9'd1 : ((cap_w > DEPTH_V) ? DEPTH_V : cap_w);

  assign sts.is_rem     = (op == bqir_pkg::OP_REM);
  assign sts.count_zero = (count == '0);
  assign sts.enq_ok     = (count_w < cap_eff);
  assign sts.pos_ok     = ({1'b0, pos} < count);
  assign sts.more       = (({1'b0, idx} + 6'd1) < {1'b0, count});

  assign occupancy = count;
  assign is_empty  = (count == '0);
  assign is_full   = (count_w >= cap_eff);

  always_comb begin
    if (cmd.read_pos) begin
      rd_addr = AW'(pos);
    end else if (cmd.shift) begin
      rd_addr = AW'(idx + 5'd2);
    end else begin
      rd_addr = AW'(idx + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.append) begin
      mem[AW'(count)] <= value;
    end else if (cmd.shift) begin
      mem[AW'(idx)] <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= bqir_pkg::CAP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (cmd.append) begin
        count <= count + 5'd1;
      end else if (cmd.shrink) begin
        count <= count - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op           <= opcode;
      value        <= task_time;
      pos          <= position;
      removed_time <= '0;
    end
    if (cmd.read_pos) begin
      idx <= {1'b0, pos};
    end else if (cmd.shift) begin
      idx <= idx + 5'd1;
    end
    if (cmd.capture) begin
      removed_time <= rd_data;
    end
    if (cmd.set_status) begin
      status <= cmd.status_code;
    end
  end

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    cmd.append |=> (count == $past(count) + 5'd1))
    else $error("append did not advance count");

  a_shrink_count: assert property (@(posedge clk) disable iff (rst)
    cmd.shrink |=> (count == $past(count) - 5'd1))
    else $error("removal did not drop count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count_w <= DEPTH_V))
    else $error("count beyond queue depth");

endmodule

// ===== hw/rtl/bounded_queue_with_indexed_removal.sv =====
// Bounded queue with append at tail and removal at an index, gaps closed up.
// Enqueues and failed removals go from acceptance through the check state to done;
//   a removal at position p goes through check and read, then stays in move while
//   later entries shift down, then strobes done. A new transaction is taken in the
//   done cycle; removal time is set by the one-entry-per-cycle memory copy.
// Reset: synchronous; clears the count and sets capacity to 16, memory untouched.
// Results cannot be stalled: done is high for one cycle per transaction.
module bounded_queue_with_indexed_removal #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [bqir_pkg::TIME_W-1:0]   task_time,
  input  logic [bqir_pkg::POS_W-1:0]    position,
  output logic                          done,
  output logic [bqir_pkg::TIME_W-1:0]   removed_time,
  output logic [bqir_pkg::STAT_W-1:0]   status,
  output logic [bqir_pkg::CNT_W-1:0]    occupancy,
  output logic                          is_empty,
  output logic                          is_full,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bqir_pkg::CNT_W-1:0]    cfg_data
);

  bqir_pkg::cmd_t cmd;
  bqir_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bqir_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  bqir_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .task_time    (task_time),
    .position     (position),
    .removed_time (removed_time),
    .status       (status),
    .occupancy    (occupancy),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

endmodule
